// ===== rtl/spq_pkg.sv =====
// spq_pkg: shared types and constants for the sorted priority queue
// used by spq_cell and sorted_priority_queue; no dependencies
package spq_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned OccW        = 5;
  localparam int unsigned DefCapacity = 16;

  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  typedef enum logic {
    OpInsert = 1'b0,
    OpRemove = 1'b1
  } op_e;

  // command broadcast to every cell
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [DataW-1:0]  value;
  } cmd_t;

endpackage

// ===== rtl/spq_cell.sv =====
// spq_cell: one slot of the sorted shift-register queue
// depends on spq_pkg for cmd_t and DataW
module spq_cell import spq_pkg::*; (
  input  logic                    clk_i,
  input  cmd_t                    cmd_i,
  input  logic                    occ_i,
  input  logic                    left_le_i,
  input  logic signed [DataW-1:0] left_val_i,
  input  logic signed [DataW-1:0] right_val_i,
  output logic                    le_o,
  output logic signed [DataW-1:0] val_o
);

  logic signed [DataW-1:0] val_q, val_d;
  logic                    own_gt;

  assign le_o   = occ_i && (val_q <= cmd_i.value);
  assign own_gt = !occ_i || (val_q > cmd_i.value);
  assign val_o  = val_q;

  always_comb begin
    val_d = val_q;
    if (cmd_i.ins) begin
      if (own_gt) begin
        val_d = left_le_i ? cmd_i.value : left_val_i;
      end
    end else if (cmd_i.rem) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// sorted_priority_queue: bounded ascending priority queue built as a row of spq_cell slots
// depends on spq_pkg and spq_cell
//
//  channel | direction | signals
//  in      | input     | in_valid_i, in_ready_o, op_i, value_i
//  out     | output    | out_valid_o, out_ready_i, removed_value_o, status_o,
//          |           | occupancy_o, is_empty_o
//
// one item per cycle unless stalled: every cell compares against the new value in
// parallel and takes the new value, its left or its right neighbor in the same edge
// the result sits in an output register; in_ready_o is high when it is empty or
// being taken, so a stalled output holds off the next item
// reset clears the entry count and the output valid flag; slot contents and result fields need no reset
module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    op_i,
  input  logic signed [DataW-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DataW-1:0] removed_value_o,
  output logic [1:0]              status_o,
  output logic [OccW-1:0]         occupancy_o,
  output logic                    is_empty_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]         count_q, count_d;
  logic                    accept;
  logic                    full, empty;
  status_e                 status_d;
  cmd_t                    cmd;
  logic                    le    [CAPACITY];
  logic signed [DataW-1:0] vals  [CAPACITY];
  logic [CntW+OccW-1:0]    occ_ext;

  logic                    out_valid_q;
  logic signed [DataW-1:0] removed_q;
  status_e                 status_q;
  logic [OccW-1:0]         occ_q;
  logic                    empty_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(CAPACITY));
  assign empty      = (count_q == '0);

  always_comb begin
    cmd.ins   = accept && (op_e'(op_i) == OpInsert) && !full;
    cmd.rem   = accept && (op_e'(op_i) == OpRemove) && !empty;
    cmd.value = value_i;
    count_d   = count_q;
    status_d  = StDone;
    if (cmd.ins) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.rem) begin
      count_d = count_q - CntW'(1);
    end
    if (op_e'(op_i) == OpInsert && full) begin
      status_d = StFull;
    end else if (op_e'(op_i) == OpRemove && empty) begin
      status_d = StEmpty;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    left_le;
    logic signed [DataW-1:0] left_val, right_val;
    if (i == 0) begin : g_first
      assign left_le  = 1'b1;
      assign left_val = vals[i];
    end else begin : g_mid
      assign left_le  = le[i-1];
      assign left_val = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_val = vals[i];
    end else begin : g_inner
      assign right_val = vals[i+1];
    end
    spq_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .occ_i       (count_q > CntW'(i)),
      .left_le_i   (left_le),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .le_o        (le[i]),
      .val_o       (vals[i])
    );
  end

  assign occ_ext = {{OccW{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      removed_q <= cmd.rem ? vals[0] : '0;
      status_q  <= status_d;
      occ_q     <= occ_ext[OccW-1:0];
      empty_q   <= (count_d == '0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign removed_value_o = removed_q;
  assign status_o        = status_q;
  assign occupancy_o     = occ_q;
  assign is_empty_o      = empty_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !accept)
    else $error("item accepted while result stalled");

  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rem |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("remove did not decrement count");

  a_refused_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cmd.ins && !cmd.rem) |=> $stable(count_q))
    else $error("refused item changed count");
`endif

endmodule

// ===== tb/sv/sorted_priority_queue_test.sv =====
// sorted_priority_queue_test: self-checking testbench for sorted_priority_queue, a directed
// table then biased random insert/remove traffic with random stalls on both channels
// depends on spq_pkg and sorted_priority_queue
module sorted_priority_queue_test import spq_pkg::*;;

  localparam int unsigned Capacity   = DefCapacity;
  localparam int          RandomRows = 1280;
  localparam int          CalmTail   = 150;
  localparam int          DrainWait  = 20;
  localparam int          CycleLimit = 200000;

  typedef struct packed {
    logic signed [DataW-1:0] removed;
    status_e                 status;
    logic [OccW-1:0]         occ;
    logic                    empty;
  } result_t;

  typedef struct packed {
    op_e                     op;
    logic signed [DataW-1:0] value;
    logic                    fixed;
    result_t                 want;
  } item_t;

  localparam result_t NoWant = '{32'sd0, StDone, 5'd0, 1'b0};

  // directed rows; fixed ones carry their expected result
  localparam item_t DirectedRows [22] = '{
    '{OpRemove, 32'sh00000000, 1'b1, '{32'sd0, StEmpty, 5'd0, 1'b1}},
    '{OpInsert, 32'sh7fffffff, 1'b1, '{32'sd0, StDone, 5'd1, 1'b0}},
    '{OpInsert, 32'sh80000000, 1'b1, '{32'sd0, StDone, 5'd2, 1'b0}},
    '{OpInsert, 32'sh00000000, 1'b0, NoWant},
    '{OpInsert, 32'shffffffff, 1'b0, NoWant},
    '{OpInsert, 32'sh00000000, 1'b0, NoWant},
    '{OpRemove, 32'shffffffff, 1'b1, '{32'sh80000000, StDone, 5'd4, 1'b0}},
    '{OpInsert, 32'sh00000001, 1'b0, NoWant},
    '{OpInsert, 32'shfffffffe, 1'b0, NoWant},
    '{OpInsert, 32'sh55555555, 1'b0, NoWant},
    '{OpInsert, 32'shaaaaaaaa, 1'b0, NoWant},
    '{OpInsert, 32'sh7ffffffe, 1'b0, NoWant},
    '{OpInsert, 32'sh80000001, 1'b0, NoWant},
    '{OpInsert, 32'sh00000064, 1'b0, NoWant},
    '{OpInsert, 32'shffffff9c, 1'b0, NoWant},
    '{OpInsert, 32'sh00000000, 1'b0, NoWant},
    '{OpInsert, 32'sh7fffffff, 1'b0, NoWant},
    '{OpInsert, 32'sh80000000, 1'b0, NoWant},
    '{OpInsert, 32'sh0000002a, 1'b0, NoWant},
    '{OpInsert, 32'sh00000005, 1'b1, '{32'sd0, StFull, 5'd16, 1'b0}},
    '{OpRemove, 32'sh00000000, 1'b1, '{32'sh80000000, StDone, 5'd15, 1'b0}},
    '{OpRemove, 32'sh00000000, 1'b0, NoWant}
  };

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    op_i = OpInsert;
  logic signed [DataW-1:0] value_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [DataW-1:0] removed_value_o;
  logic [1:0]              status_o;
  logic [OccW-1:0]         occupancy_o;
  logic                    is_empty_o;

  sorted_priority_queue #(
    .CAPACITY(Capacity)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .removed_value_o(removed_value_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o),
    .is_empty_o     (is_empty_o)
  );

  item_t                   pending_items [$];
  result_t                 awaited_results [$];
  item_t                   driven_item;
  logic signed [DataW-1:0] model_slots [Capacity];
  int unsigned             model_count = 0;
  int                      send_gap = 0;
  int                      stall_left = 0;
  int                      cycle_count = 0;
  bit                      failed = 1'b0;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // next state of the sorted store and the result the item yields
  function automatic result_t predict_queue_result(op_e op, logic signed [DataW-1:0] value);
    result_t     res;
    int unsigned pos;
    int unsigned i;
    res = NoWant;
    if (op == OpInsert) begin
      if (model_count >= Capacity) begin
        res.status = StFull;
      end else begin
        pos = 0;
        while (pos < model_count && model_slots[pos] <= value) pos++;
        for (i = model_count; i > pos; i--) model_slots[i] = model_slots[i-1];
        model_slots[pos] = value;
        model_count++;
      end
    end else begin
      if (model_count == 0) begin
        res.status = StEmpty;
      end else begin
        res.removed = model_slots[0];
        for (i = 1; i < model_count; i++) model_slots[i-1] = model_slots[i];
        model_count--;
      end
    end
    res.occ   = model_count[OccW-1:0];
    res.empty = (model_count == 0);
    return res;
  endfunction

  function automatic logic signed [DataW-1:0] pick_value(ref logic signed [DataW-1:0] seen [$]);
    int unsigned mode;
    mode = $urandom_range(0, 99);
    if (mode < 40) return $urandom;
    if (mode < 70) return $urandom_range(0, 15) - 8;
    if (mode < 85 && seen.size() != 0) return seen[$urandom_range(0, seen.size() - 1)];
    case ($urandom_range(0, 3))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return 32'sh00000000;
      default: return 32'shffffffff;
    endcase
  endfunction

  function automatic void build_random_items();
    logic signed [DataW-1:0] seen [$];
    item_t                   it;
    int                      phase_left;
    int unsigned             insert_pct;
    int                      n;
    phase_left = 0;
    insert_pct = 50;
    for (n = 0; n < RandomRows; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 80);
        case ($urandom_range(0, 4))
          0: insert_pct = 90;
          1: insert_pct = 70;
          2: insert_pct = 50;
          3: insert_pct = 30;
          default: insert_pct = 10;
        endcase
      end
      phase_left--;
      it       = '{OpInsert, 32'sd0, 1'b0, NoWant};
      it.op    = ($urandom_range(0, 99) < insert_pct) ? OpInsert : OpRemove;
      it.value = (it.op == OpInsert) ? pick_value(seen) : $urandom;
      if (it.op == OpInsert) seen.push_back(it.value);
      if (seen.size() > 32) void'(seen.pop_front());
      pending_items.push_back(it);
    end
  endfunction

  // input side: accept, predict, then present the next item or idle
  always @(posedge clk_i) begin
    result_t res;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        res = predict_queue_result(driven_item.op, driven_item.value);
        awaited_results.push_back(driven_item.fixed ? driven_item.want : res);
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > CalmTail && $urandom_range(0, 15) == 0) begin
          send_gap = $urandom_range(1, 13) - 1;
          in_valid_i <= 1'b0;
        end else begin
          driven_item = pending_items.pop_front();
          in_valid_i <= 1'b1;
          op_i       <= driven_item.op;
          value_i    <= driven_item.value;
        end
      end
    end
  end

  // output side: check accepted results, stall in bursts
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result removed_value=%0d status=%0d occupancy=%0d",
                   $time, removed_value_o, status_o, occupancy_o);
          failed = 1'b1;
        end else begin
          want = awaited_results.pop_front();
          if (removed_value_o !== want.removed) begin
            $display("%0t: removed_value expected %0d actual %0d", $time, want.removed,
                     removed_value_o);
            failed = 1'b1;
          end
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
            failed = 1'b1;
          end
          if (occupancy_o !== want.occ) begin
            $display("%0t: occupancy expected %0d actual %0d", $time, want.occ, occupancy_o);
            failed = 1'b1;
          end
          if (is_empty_o !== want.empty) begin
            $display("%0t: is_empty expected %0d actual %0d", $time, want.empty, is_empty_o);
            failed = 1'b1;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (pending_items.size() > CalmTail && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("sorted_priority_queue: mismatch");
      $finish;
    end
  end

  initial begin
    int n;
    rst_ni <= 1'b0;
    for (n = 0; n < $size(DirectedRows); n++) pending_items.push_back(DirectedRows[n]);
    build_random_items();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || awaited_results.size() != 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (!failed) begin
      $display("sorted_priority_queue: match");
    end else begin
      $display("sorted_priority_queue: mismatch");
    end
    $finish;
  end

endmodule
